[src/rsl_pkg.sv]
// Package for the radial spotlight luminance block.
// Holds widths, constants, register indexes and the square-root pipe struct.
// No dependencies.
package rsl_pkg;

  localparam int COORD_BITS     = 12;
  localparam int LUM_BITS       = 16;
  localparam int DIST_FRAC_BITS = 4;

  localparam int CENTER_BITS  = COORD_BITS + 2;
  localparam int DIFF_BITS    = COORD_BITS + 2;
  localparam int SQ_BITS      = 2 * DIFF_BITS + 1;

  // distance cap in whole pixels; sq at or above its square saturates
  localparam int DIST_CAP_PIX = 160;
  localparam int SQ_CAP       = DIST_CAP_PIX * DIST_CAP_PIX;
  localparam int SQC_BITS     = 15;

  localparam int ROOT_BITS     = 8 + DIST_FRAC_BITS;
  localparam int SQRT_STEPS    = 3;
  localparam int SQRT_STAGES   = (ROOT_BITS + SQRT_STEPS - 1) / SQRT_STEPS;
  localparam int ROOT_PAD_BITS = SQRT_STAGES * SQRT_STEPS;
  localparam int RAD_BITS      = 2 * ROOT_PAD_BITS;
  localparam int REM_BITS      = ROOT_PAD_BITS + 2;

  // keep / (200 << DF) == keep / (25 << (DF + 3))
  localparam int KEEP_BITS   = 8 + DIST_FRAC_BITS;
  localparam int KEEP_SHIFT  = DIST_FRAC_BITS + 3;
  localparam int DIV_ODD     = 25;
  localparam int PROD_BITS   = LUM_BITS + KEEP_BITS;
  localparam int X_BITS      = PROD_BITS - KEEP_SHIFT;
  localparam int RECIP_SHIFT = X_BITS + 5;
  localparam int RECIP_BITS  = X_BITS + 1;
  localparam int MUL_BITS    = X_BITS + RECIP_BITS;

  localparam logic [KEEP_BITS-1:0]  KEEP_DEN = KEEP_BITS'(200 << DIST_FRAC_BITS);
  localparam logic [KEEP_BITS-1:0]  DIST_CAP = KEEP_BITS'(DIST_CAP_PIX << DIST_FRAC_BITS);
  localparam logic [RECIP_BITS-1:0] RECIP    =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD));

  // three front stages, sqrt stages, two back stages, output reg
  localparam int PIPE_DEPTH = 6 + SQRT_STAGES;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_COL = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_ROW = 2'd1;

  typedef struct packed {
    logic                     valid;
    logic                     sat;
    logic [LUM_BITS-1:0]      lum;
    logic [RAD_BITS-1:0]      rad;
    logic [REM_BITS-1:0]      rem;
    logic [ROOT_PAD_BITS-1:0] root;
  } sqrt_pipe_t;

endpackage

[src/rsl_sqrt_stage.sv]
// One registered stage of the digit-by-digit integer square root.
// Resolves SQRT_STEPS root bits per cycle; depends on rsl_pkg.
module rsl_sqrt_stage import rsl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sqrt_pipe_t pipe_in,
  output sqrt_pipe_t pipe_out
);

  sqrt_pipe_t pipe_r;
  sqrt_pipe_t pipe_nxt;

  always_comb begin
    logic [REM_BITS-1:0]      rem_v;
    logic [REM_BITS-1:0]      trial_v;
    logic [RAD_BITS-1:0]      rad_v;
    logic [ROOT_PAD_BITS-1:0] root_v;
    rem_v  = pipe_in.rem;
    rad_v  = pipe_in.rad;
    root_v = pipe_in.root;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      rem_v   = {rem_v[REM_BITS-3:0], rad_v[RAD_BITS-1 -: 2]};
      rad_v   = {rad_v[RAD_BITS-3:0], 2'b00};
      trial_v = {root_v, 2'b01};
      if (rem_v >= trial_v) begin
        rem_v  = rem_v - trial_v;
        root_v = {root_v[ROOT_PAD_BITS-2:0], 1'b1};
      end else begin
        root_v = {root_v[ROOT_PAD_BITS-2:0], 1'b0};
      end
    end
    pipe_nxt      = pipe_in;
    pipe_nxt.rem  = rem_v;
    pipe_nxt.rad  = rad_v;
    pipe_nxt.root = root_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r <= '0;
    end else begin
      pipe_r <= pipe_nxt;
    end
  end

  assign pipe_out = pipe_r;

endmodule

[src/radial_spotlight_luminance_top.sv]
// Throughput: one item per cycle; busy is low whenever reset is released.
// The square root resolves three root bits per stage; the scale is a multiply
// by lum followed by a reciprocal multiply for the divide by 25.
// Synchronous active-low reset clears the pipeline valids and both center regs.
// Top level of the radial spotlight luminance block; depends on rsl_pkg, rsl_sqrt_stage.
module radial_spotlight_luminance_top import rsl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [COORD_BITS-1:0]   in_pixel_col,
  input  logic [COORD_BITS-1:0]   in_pixel_row,
  input  logic [LUM_BITS-1:0]     in_lum_in,
  output logic                    out_valid,
  output logic [LUM_BITS-1:0]     out_lum_out,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CENTER_BITS-1:0]  cfg_wdata
);

  logic [CENTER_BITS-1:0] center_col_r;
  logic [CENTER_BITS-1:0] center_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_col_r <= '0;
      center_row_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_COL: center_col_r <= cfg_wdata;
        REG_CENTER_ROW: center_row_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = !rst_n;

  logic accept;
  assign accept = start && !busy;

  // stage 1: absolute offsets
  logic signed [DIFF_BITS:0] dc_nxt;
  logic signed [DIFF_BITS:0] dr_nxt;
  logic [DIFF_BITS-1:0]      adc_nxt;
  logic [DIFF_BITS-1:0]      adr_nxt;
  logic                      s1_valid_r;
  logic [DIFF_BITS-1:0]      adc_r;
  logic [DIFF_BITS-1:0]      adr_r;
  logic [LUM_BITS-1:0]       s1_lum_r;

  always_comb begin
    dc_nxt  = $signed({center_col_r[CENTER_BITS-1], center_col_r})
            - $signed({3'b000, in_pixel_col});
    dr_nxt  = $signed({center_row_r[CENTER_BITS-1], center_row_r})
            - $signed({3'b000, in_pixel_row});
    adc_nxt = dc_nxt[DIFF_BITS] ? DIFF_BITS'(-dc_nxt) : dc_nxt[DIFF_BITS-1:0];
    adr_nxt = dr_nxt[DIFF_BITS] ? DIFF_BITS'(-dr_nxt) : dr_nxt[DIFF_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    adc_r    <= adc_nxt;
    adr_r    <= adr_nxt;
    s1_lum_r <= in_lum_in;
  end

  // stage 2: squares
  logic                     s2_valid_r;
  logic [2*DIFF_BITS-1:0]   sqc_r;
  logic [2*DIFF_BITS-1:0]   sqr_r;
  logic [LUM_BITS-1:0]      s2_lum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    sqc_r    <= (2*DIFF_BITS)'(adc_r) * (2*DIFF_BITS)'(adc_r);
    sqr_r    <= (2*DIFF_BITS)'(adr_r) * (2*DIFF_BITS)'(adr_r);
    s2_lum_r <= s1_lum_r;
  end

  // stage 3: sum, saturate, build radicand
  logic [SQ_BITS-1:0] sq_sum;
  logic               sat_nxt;
  sqrt_pipe_t         s3_pipe_nxt;
  sqrt_pipe_t         s3_pipe_r;

  always_comb begin
    sq_sum            = SQ_BITS'(sqc_r) + SQ_BITS'(sqr_r);
    sat_nxt           = (sq_sum >= SQ_BITS'(SQ_CAP));
    s3_pipe_nxt.valid = s2_valid_r;
    s3_pipe_nxt.sat   = sat_nxt;
    s3_pipe_nxt.lum   = s2_lum_r;
    s3_pipe_nxt.rad   = sat_nxt ? '0
                      : RAD_BITS'(sq_sum[SQC_BITS-1:0]) << (2*DIST_FRAC_BITS);
    s3_pipe_nxt.rem   = '0;
    s3_pipe_nxt.root  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_pipe_r <= '0;
    end else begin
      s3_pipe_r <= s3_pipe_nxt;
    end
  end

  // square-root stages
  sqrt_pipe_t sq_pipe [SQRT_STAGES+1];
  assign sq_pipe[0] = s3_pipe_r;

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    rsl_sqrt_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .pipe_in  (sq_pipe[g]),
      .pipe_out (sq_pipe[g+1])
    );
  end

  sqrt_pipe_t sq_last;
  assign sq_last = sq_pipe[SQRT_STAGES];

  // keep share and product
  logic [KEEP_BITS-1:0] dist_val;
  logic [KEEP_BITS-1:0] keep;
  logic                 p_valid_r;
  logic [PROD_BITS-1:0] prod_r;

  always_comb begin
    dist_val = sq_last.sat ? DIST_CAP : sq_last.root[ROOT_BITS-1:0];
    keep     = KEEP_DEN - dist_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= sq_last.valid;
    end
    prod_r <= PROD_BITS'(sq_last.lum) * PROD_BITS'(keep);
  end

  // divide by the odd factor through a reciprocal multiply
  logic [X_BITS-1:0]   xq;
  logic                m_valid_r;
  logic [MUL_BITS-1:0] mul_r;

  assign xq = prod_r[PROD_BITS-1:KEEP_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= p_valid_r;
    end
    mul_r <= MUL_BITS'(xq) * MUL_BITS'(RECIP);
  end

  // output register
  logic                out_valid_r;
  logic [LUM_BITS-1:0] out_lum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= m_valid_r;
    end
    out_lum_r <= mul_r[RECIP_SHIFT +: LUM_BITS];
  end

  assign out_valid   = out_valid_r;
  assign out_lum_out = out_lum_r;

endmodule

[src/rsl_checker.sv]
// Port-level checker for radial_spotlight_luminance_top, attached by bind.
// Depends on rsl_pkg for the pipeline depth and widths.
module rsl_checker import rsl_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [LUM_BITS-1:0] in_lum_in,
  input logic                out_valid,
  input logic [LUM_BITS-1:0] out_lum_out
);

  logic accept;
  assign accept = start && !busy;

  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_DEPTH out_valid)
    else $error("item accepted but no result after pipeline depth");

  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_DEPTH))
    else $error("result without a matching accepted item");

  a_no_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lum_out <= $past(in_lum_in, PIPE_DEPTH)))
    else $error("luminance increased");

  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lum_out >= $past(in_lum_in, PIPE_DEPTH) / 5))
    else $error("luminance cut beyond eighty percent");

endmodule

bind radial_spotlight_luminance_top rsl_checker u_rsl_checker (.*);
